// File: rtl/smf_pkg.sv
// Shared types, constants and the sine table for the sine-modulated flanger.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package smf_pkg;

	localparam int DELAY_DEPTH     = 1024;
	localparam int SINE_TABLE_BITS = 8;
	localparam int ADDR_W          = $clog2(DELAY_DEPTH);
	localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef logic signed [15:0] sample_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [ADDR_W:0]    fill_t;

	// register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_MODE         = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_PERIOD_COUNT = 2'd2,
		REG_HALF_DEPTH   = 2'd3
	} reg_idx_t;

	localparam logic [31:0] PHASE_STEP_RST   = 32'd80530;
	localparam logic [23:0] PERIOD_COUNT_RST = 24'd53333;
	localparam logic [8:0]  HALF_DEPTH_RST   = 9'd240;

	// odd polynomial coefficients of the quarter-wave sine, Q30
	localparam longint unsigned SQ_C1 = 64'd1686629713;
	localparam longint unsigned SQ_C3 = 64'd693598670;
	localparam longint unsigned SQ_C5 = 64'd85569306;
	localparam longint unsigned SQ_C7 = 64'd5026995;
	localparam longint unsigned SQ_C9 = 64'd172272;

	typedef logic signed [15:0] sine_tbl_t [SINE_SIZE];

	// x in Q15 over [0, 1] standing for 0..pi/2, result Q15 clamped to 32767
	function automatic logic [15:0] quarter_sine(longint unsigned x);
		longint unsigned x2;
		longint unsigned p;
		longint unsigned r;
		x2 = x * x;
		p  = SQ_C9;
		p  = SQ_C7 - ((p * x2) >> 30);
		p  = SQ_C5 - ((p * x2) >> 30);
		p  = SQ_C3 - ((p * x2) >> 30);
		p  = SQ_C1 - ((p * x2) >> 30);
		r  = (p * x + (64'd1 << 29)) >> 30;
		if (r > 64'd32767)
			r = 64'd32767;
		return 16'(r);
	endfunction

	function automatic logic signed [15:0] sine_entry(int unsigned k);
		int unsigned     q;
		int unsigned     r;
		longint unsigned x;
		logic signed [15:0] s;
		q = (k >> (SINE_TABLE_BITS - 2)) & 32'd3;
		r = k & ((32'd1 << (SINE_TABLE_BITS - 2)) - 32'd1);
		x = 64'(r) << (17 - SINE_TABLE_BITS);
		if (q[0])
			s = quarter_sine(64'd32768 - x);
		else
			s = quarter_sine(x);
		return q[1] ? -s : s;
	endfunction

	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t t;
		for (int i = 0; i < SINE_SIZE; i++)
			t[i] = sine_entry(i);
		return t;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

`default_nettype wire

// File: rtl/smf_if.sv
// Valid/ready stream interfaces for input samples and result samples.
// Depends on smf_pkg for the sample type.
`default_nettype none

interface smf_sample_if;
	import smf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface smf_result_if;
	import smf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/smf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module smf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// File: rtl/sine_modulated_flanger_top.sv
// Sine-modulated flanger: APB register file, LFO, delay-tap pipeline and output register.
// Depends on smf_pkg, smf_sample_if / smf_result_if and smf_ram.
//
// Usage:
//   sample_ch carries one signed 16-bit audio sample per beat, result_ch one
//   result sample per beat; every input beat gives exactly one result beat,
//   in order. Registers (mode, phase_step, period_count, half_depth) are
//   written over the APB port at byte addresses 0, 4, 8, 12; the user must
//   write them only while the block is idle; the block itself does not enforce this.
//   pready is always high. A sample passes through the phase update, sine
//   lookup, delay multiply, delay-line write/read and saturating add into
//   the output register on its way to result_ch.
//   Throughput: one sample per cycle while result_ch takes results; the delay
//   line takes one write and one read per cycle at the same stage, which sets that figure.
//   Reset clears registers to their defaults, the LFO phase, period counter
//   and write pointer. The delay line itself is not swept: a fill count marks
//   which entries hold samples, and taps on unwritten entries read as zero,
//   so the block takes samples right after reset.
//   When result_ch stalls, the pipeline keeps filling empty stages and
//   sample_ch.ready drops only when every stage holds a sample.
`default_nettype none

module sine_modulated_flanger_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	smf_sample_if.sink                         sample_ch,
	smf_result_if.source                       result_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [smf_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [smf_pkg::PDATA_W-1:0]   pwdata,
	output logic      [smf_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import smf_pkg::*;

	typedef enum logic [1:0] {
		TAP_ZERO = 2'd0,
		TAP_SELF = 2'd1,
		TAP_MEM  = 2'd2
	} tap_t;

	// ---------------- registers ----------------
	logic        mode_q;
	logic [31:0] phase_step_q;
	logic [23:0] period_count_q;
	logic [8:0]  half_depth_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			phase_step_q   <= PHASE_STEP_RST;
			period_count_q <= PERIOD_COUNT_RST;
			half_depth_q   <= HALF_DEPTH_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:         mode_q         <= pwdata[0];
				REG_PHASE_STEP:   phase_step_q   <= pwdata;
				REG_PERIOD_COUNT: period_count_q <= pwdata[23:0];
				REG_HALF_DEPTH:   half_depth_q   <= pwdata[8:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:         prdata = {31'd0, mode_q};
			REG_PHASE_STEP:   prdata = phase_step_q;
			REG_PERIOD_COUNT: prdata = {8'd0, period_count_q};
			REG_HALF_DEPTH:   prdata = {23'd0, half_depth_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic go1, go2, go3, go4, go5;
	logic accept;

	assign go5 = !v_s5 || result_ch.ready;
	assign go4 = !v_s4 || go5;
	assign go3 = !v_s3 || go4;
	assign go2 = !v_s2 || go3;
	assign go1 = !v_s1 || go2;

	assign sample_ch.ready = go1;
	assign accept          = sample_ch.valid && go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (go1) v_s1 <= sample_ch.valid;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
			if (go4) v_s4 <= v_s3;
			if (go5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: LFO phase and period counter ----------------
	logic [31:0] lfo_phase_q;
	logic [23:0] period_ctr_q;
	logic [31:0] phase_sum;
	logic [23:0] ctr_inc;
	logic        wrap;
	logic [31:0] phase_next;

	assign phase_sum  = lfo_phase_q + phase_step_q;
	assign ctr_inc    = period_ctr_q + 24'd1;
	assign wrap       = ctr_inc >= period_count_q;
	assign phase_next = wrap ? 32'd0 : phase_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_phase_q  <= '0;
			period_ctr_q <= '0;
		end else if (accept && mode_q) begin
			lfo_phase_q  <= phase_next;
			period_ctr_q <= wrap ? 24'd0 : ctr_inc;
		end
	end

	logic                       byp_s1;
	sample_t                    x_s1;
	logic [SINE_TABLE_BITS-1:0] k_s1;

	always_ff @(posedge clk) begin
		if (go1) begin
			byp_s1 <= !mode_q;
			x_s1   <= sample_ch.sample_in;
			k_s1   <= phase_next[31 -: SINE_TABLE_BITS];
		end
	end

	// ---------------- stage 2: sine lookup ----------------
	logic    byp_s2;
	sample_t x_s2;
	sample_t sin_s2;

	always_ff @(posedge clk) begin
		if (go2) begin
			byp_s2 <= byp_s1;
			x_s2   <= x_s1;
			sin_s2 <= SINE_TBL[k_s1];
		end
	end

	// ---------------- stage 3: delay = ceil(half_depth * (1 + sin)) ----------------
	localparam int PROD_W = 26;
	localparam int NQ_W   = PROD_W - 15;

	logic [15:0]       offs;
	logic [PROD_W-1:0] prod;
	logic [NQ_W-1:0]   nq;
	addr_t             n_next;

	assign offs = 16'(17'sd32768 + 17'(sin_s2));
	assign prod = PROD_W'(half_depth_q) * PROD_W'(offs) + PROD_W'(32767);
	assign nq   = prod[PROD_W-1:15];

	always_comb begin
		if (32'(nq) > 32'(DELAY_DEPTH - 1))
			n_next = ADDR_W'(DELAY_DEPTH - 1);
		else
			n_next = ADDR_W'(nq);
	end

	logic    byp_s3;
	sample_t x_s3;
	addr_t   n_s3;

	always_ff @(posedge clk) begin
		if (go3) begin
			byp_s3 <= byp_s2;
			x_s3   <= x_s2;
			n_s3   <= n_next;
		end
	end

	// ---------------- stage 4: delay line write and tap read ----------------
	addr_t          wp_q;
	fill_t          fill_q;
	logic           mem_go;
	logic           mem_we;
	logic [ADDR_W:0] rd_wrap;
	addr_t          rd_addr;
	sample_t        rdata;
	tap_t           tap_next;

	assign mem_go  = v_s3 && go4;
	assign mem_we  = mem_go && !byp_s3;
	assign rd_wrap = {1'b0, wp_q} + (ADDR_W + 1)'(DELAY_DEPTH) - {1'b0, n_s3};
	assign rd_addr = (wp_q >= n_s3) ? (wp_q - n_s3) : rd_wrap[ADDR_W-1:0];

	always_comb begin
		if (n_s3 == '0)
			tap_next = TAP_SELF;
		else if ({1'b0, n_s3} > fill_q)
			tap_next = TAP_ZERO;   // slot not yet written since reset
		else
			tap_next = TAP_MEM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (mem_we) begin
			wp_q <= (wp_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != fill_t'(DELAY_DEPTH))
				fill_q <= fill_q + 1'b1;
		end
	end

	smf_ram #(
		.WIDTH (16),
		.DEPTH (DELAY_DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (x_s3),
		.re    (mem_go),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	logic    byp_s4;
	sample_t x_s4;
	tap_t    tap_s4;

	always_ff @(posedge clk) begin
		if (go4) begin
			byp_s4 <= byp_s3;
			x_s4   <= x_s3;
			tap_s4 <= tap_next;
		end
	end

	// ---------------- stage 5: saturating add, output register ----------------
	sample_t            tap_val;
	logic signed [16:0] sum;
	sample_t            y_next;
	sample_t            y_s5;

	always_comb begin
		case (tap_s4)
			TAP_SELF: tap_val = x_s4;
			TAP_MEM:  tap_val = rdata;
			default:  tap_val = '0;
		endcase
		if (byp_s4)
			tap_val = '0;
	end

	assign sum = 17'(x_s4) + 17'(tap_val);

	always_comb begin
		if (sum[16] != sum[15])
			y_next = sum[16] ? 16'sh8000 : 16'sh7fff;
		else
			y_next = sum[15:0];
	end

	always_ff @(posedge clk) begin
		if (go5)
			y_s5 <= y_next;
	end

	assign result_ch.valid      = v_s5;
	assign result_ch.sample_out = y_s5;

	// ---------------- assertions ----------------
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < DELAY_DEPTH)
		else $error("write pointer beyond delay line");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= DELAY_DEPTH)
		else $error("fill count beyond delay depth");

	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> fill_q != '0)
		else $error("delay line written but fill count is zero");

	a_stall_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && v_s5 && !result_ch.ready |=> v_s4 && $stable(x_s4) && $stable(tap_s4))
		else $error("stage 4 moved while output stalled");

endmodule

`default_nettype wire

// File: sim/sine_modulated_flanger_top_tb.sv
// Self-checking testbench for sine_modulated_flanger_top: a predictor of the flanger
// checks every result beat while the APB registers step through bypass and flange settings.
// Depends on smf_pkg, smf_if.sv and the RTL of the top level.

module sine_modulated_flanger_top_tb;
	import smf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 125;

	// quarter-wave sine polynomial in Q30, innermost coefficient first
	localparam longint unsigned SINE_POLY_Q30 [5] = '{
		64'd172272, 64'd5026995, 64'd85569306, 64'd693598670, 64'd1686629713
	};

	typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_STALLS} rx_style_t;

	class flange_checker;
		bit                 mode;
		bit [31:0]          phase_step;
		bit [23:0]          period_count;
		bit [8:0]           half_depth;
		sample_t            delay_line [DELAY_DEPTH];
		addr_t              wr_ptr;
		bit [31:0]          phase;
		bit [23:0]          period_cnt;
		logic signed [15:0] sine_lut [SINE_SIZE];
		sample_t            expected_out [$];
		int                 failures;

		function new();
			longint unsigned x;
			longint unsigned mag;
			logic signed [15:0] m16;
			int quad;
			for (int k = 0; k < SINE_SIZE; k++) begin
				quad = k >> (SINE_TABLE_BITS - 2);
				x    = 64'(k & ((1 << (SINE_TABLE_BITS - 2)) - 1)) << (17 - SINE_TABLE_BITS);
				mag  = quad[0] ? quarter_wave(64'd32768 - x) : quarter_wave(x);
				m16  = 16'(mag);
				sine_lut[k] = quad[1] ? -m16 : m16;
			end
			foreach (delay_line[i])
				delay_line[i] = '0;
			wr_ptr       = '0;
			phase        = '0;
			period_cnt   = '0;
			mode         = 1'b0;
			phase_step   = PHASE_STEP_RST;
			period_count = PERIOD_COUNT_RST;
			half_depth   = HALF_DEPTH_RST;
			failures     = 0;
		endfunction

		// Horner steps truncate, final product rounds half up
		function longint unsigned quarter_wave(longint unsigned x);
			longint unsigned x2;
			longint unsigned acc;
			longint unsigned r;
			x2  = x * x;
			acc = SINE_POLY_Q30[0];
			for (int i = 1; i < 5; i++)
				acc = SINE_POLY_Q30[i] - ((acc * x2) >> 30);
			r = (acc * x + (64'd1 << 29)) >> 30;
			return (r > 64'd32767) ? 64'd32767 : r;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_MODE:         mode = v[0];
				REG_PHASE_STEP:   phase_step = v;
				REG_PERIOD_COUNT: period_count = v[23:0];
				REG_HALF_DEPTH:   half_depth = v[8:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t x);
			int          sum;
			int unsigned tap;
			int          y;
			addr_t       rd;
			if (!mode) begin
				expected_out.push_back(x);
				return;
			end
			delay_line[wr_ptr] = x;
			phase      += phase_step;
			period_cnt += 24'd1;
			if (period_cnt >= period_count) begin
				period_cnt = '0;
				phase      = '0;
			end
			sum = 32768 + int'(sine_lut[phase[31:32-SINE_TABLE_BITS]]);
			tap = 32'(half_depth) * unsigned'(sum) + 32'd32767;
			tap = tap >> 15;
			if (tap > DELAY_DEPTH - 1)
				tap = DELAY_DEPTH - 1;
			rd = wr_ptr - addr_t'(tap);
			y  = int'(x) + int'(delay_line[rd]);
			if (y > 32767)
				y = 32767;
			else if (y < -32768)
				y = -32768;
			wr_ptr++;
			expected_out.push_back(sample_t'(y));
		endfunction

		function void check_result(sample_t got);
			sample_t want;
			if (expected_out.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result beat: sample_out %0d", got);
				return;
			end
			want = expected_out.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("sample_out mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	smf_sample_if sample_ch();
	smf_result_if result_ch();

	flange_checker sb;
	int            burst_left;
	int            tx_max_gap;
	rx_style_t     rx_style;
	int            rx_left;
	int            stall_left;
	int            idle_cycles;

	sine_modulated_flanger_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'({idx, 2'b00});
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic apply_settings(bit m, logic [31:0] ps, logic [23:0] pc, logic [8:0] hd);
		write_reg(REG_MODE, {31'b0, m});
		write_reg(REG_PHASE_STEP, ps);
		write_reg(REG_PERIOD_COUNT, {8'b0, pc});
		write_reg(REG_HALF_DEPTH, {23'b0, hd});
	endtask

	// caller sits at a falling edge; valid stays high across a burst
	task automatic send_sample(sample_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
			if (gap != 0) begin
				sample_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		sample_ch.valid     = 1'b1;
		sample_ch.sample_in = s;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
		burst_left--;
	endtask

	// registers change only with the pipeline empty
	task automatic drain();
		sample_ch.valid = 1'b0;
		burst_left      = 0;
		while (sb.expected_out.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return sample_t'($signed(8'($urandom)));
			default: return sample_t'($urandom);
		endcase
	endfunction

	// result side: steady, choppy or long-stall stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			rx_left  = $urandom_range(40, 400);
		end else begin
			rx_left--;
		end
		case (rx_style)
			RX_STEADY: result_ch.ready = 1'b1;
			RX_CHOPPY: result_ch.ready = ($urandom_range(0, 2) != 0);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					result_ch.ready = 1'b0;
				end else begin
					result_ch.ready = 1'b1;
					if ($urandom_range(0, 19) == 0)
						stall_left = $urandom_range(4, 24);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.sample_in);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.sample_out);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sample_t     edge_vals [7];
		sample_t     sat_vals [5];
		bit          m;
		logic [31:0] ps;
		logic [23:0] pc;
		logic [8:0]  hd;

		sb                  = new();
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.sample_in = '0;
		result_ch.ready     = 1'b0;
		burst_left          = 0;
		tx_max_gap          = 0;
		rx_style            = RX_STEADY;
		rx_left             = 0;
		stall_left          = 0;
		idle_cycles         = 0;
		edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
		sat_vals  = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// bypass at reset settings
		foreach (edge_vals[i])
			send_sample(edge_vals[i]);
		drain();

		// zero depth: tap is the sample itself, so x+x saturates both ways
		apply_settings(1'b1, PHASE_STEP_RST, PERIOD_COUNT_RST, 9'd0);
		foreach (sat_vals[i])
			send_sample(sat_vals[i]);
		drain();

		// deepest tap, phase wraps every beat
		apply_settings(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'd511);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h1234);
		drain();

		// period count of zero pins the phase at zero
		apply_settings(1'b1, 32'h4000_0000, 24'd0, 9'd300);
		repeat (4) send_sample(pick_sample());
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			m = (p == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
			case ($urandom_range(0, 4))
				0:       ps = 32'd0;
				1:       ps = 32'hFFFF_FFFF;
				2:       ps = 32'h0100_0000;
				3:       ps = $urandom_range(1, 1 << 26);
				default: ps = $urandom;
			endcase
			// long period first, then one far below the counter it left behind
			if (p == 0)
				pc = 24'hFF_FFFF;
			else if (p == 1)
				pc = 24'd3;
			else begin
				case ($urandom_range(0, 3))
					0:       pc = 24'd1;
					1:       pc = 24'hFF_FFFF;
					2:       pc = $urandom_range(2, 300);
					default: pc = 24'($urandom);
				endcase
			end
			case ($urandom_range(0, 3))
				0:       hd = 9'd0;
				1:       hd = 9'd511;
				default: hd = $urandom_range(0, 511);
			endcase
			if (p == 0)
				ps = $urandom;
			apply_settings(m, ps, pc, hd);
			tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (PHASE_ITEMS) send_sample(pick_sample());
			drain();
		end

		if (sb.failures == 0 && sb.expected_out.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
